/* rtl/core/cpbbt_pkg.sv */
// shared types, register codes and reset values of the back-to-back cluster pair tagger
package cpbbt_pkg;

	localparam int MAX_CLUSTERS_DEF = 16;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 36;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_VETO_LIMITS   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SELECT_LIMITS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAIR_CEILING  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_VETO_WINDOW   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SELECT_WINDOW = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PAIR_WINDOW   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RING_RANGE    = 3'd6;

	// reset values
	localparam logic [15:0] VETO_LIMITS_RST   = 16'd11550;
	localparam logic [15:0] SELECT_LIMITS_RST = 16'd10265;
	localparam logic [7:0]  PAIR_CEILING_RST  = 8'd20;
	localparam logic [26:0] VETO_WINDOW_RST   = 27'd49892000;
	localparam logic [35:0] SELECT_WINDOW_RST = 36'd26885601420;
	localparam logic [35:0] PAIR_WINDOW_RST   = 36'd25544724640;
	localparam logic [9:0]  RING_RANGE_RST    = 10'd483;

	localparam logic [8:0]  PHI_FOLD      = 9'd180;
	localparam logic [10:0] PHI_FULL      = 11'd360;
	localparam logic [4:0]  RING_LIMIT    = 5'd18;
	localparam logic [3:0]  CEILING_SCALE = 4'd10;

	// veto in-track class codes
	localparam logic [1:0] VCLS_NONE    = 2'd0;
	localparam logic [1:0] VCLS_OUTSIDE = 2'd1;
	localparam logic [1:0] VCLS_INSIDE  = 2'd2;

	// selection ring class codes
	localparam logic [2:0] SCLS_NONE    = 3'd0;
	localparam logic [2:0] SCLS_OUTSIDE = 3'd1;
	localparam logic [2:0] SCLS_OTHER   = 3'd5;

	// one stored cluster, tower in the lowest bits
	typedef struct packed {
		logic [4:0]  theta_ring;
		logic [7:0]  theta_deg;
		logic [8:0]  phi_deg;
		logic [3:0]  energy_scale;
		logic [11:0] energy_centi;
		logic [9:0]  tower_id;
	} cluster_t;

	// one result, veto_hit in the lowest bit
	typedef struct packed {
		logic        low_pair_hit;
		logic [9:0]  select_tower_b;
		logic [9:0]  select_tower_a;
		logic [2:0]  select_ring_class;
		logic        select_hit;
		logic [9:0]  veto_tower_b;
		logic [9:0]  veto_tower_a;
		logic [1:0]  veto_track_class;
		logic        veto_hit;
	} result_t;

	// both energies above low*scale and one above high*scale
	function automatic logic energy_pass(cluster_t a, cluster_t b, logic [15:0] limits);
		logic [11:0] lo_a;
		logic [11:0] lo_b;
		logic [11:0] hi_a;
		logic [11:0] hi_b;
		lo_a = {4'd0, limits[7:0]} * {8'd0, a.energy_scale};
		lo_b = {4'd0, limits[7:0]} * {8'd0, b.energy_scale};
		hi_a = {4'd0, limits[15:8]} * {8'd0, a.energy_scale};
		hi_b = {4'd0, limits[15:8]} * {8'd0, b.energy_scale};
		return (a.energy_centi > lo_a) && (b.energy_centi > lo_b) &&
			((a.energy_centi > hi_a) || (b.energy_centi > hi_b));
	endfunction

	// open window on the signed folded phi difference
	function automatic logic phi_above(logic signed [10:0] dphi, logic [8:0] lo);
		return dphi > $signed({2'b00, lo});
	endfunction

	function automatic logic phi_below(logic signed [10:0] dphi, logic [8:0] hi);
		return dphi < $signed({2'b00, hi});
	endfunction

	function automatic logic sum_window(logic [8:0] tsum, logic [8:0] lo, logic [8:0] hi);
		return (tsum > lo) && (tsum < hi);
	endfunction

endpackage

/* rtl/core/cluster_pair_back_to_back_tagger.sv */
// back-to-back cluster pair tagger: cluster memory, pair scan sequencer and result register
// a non-last item is taken while loading; the last item of an event with n clusters
// starts a scan that reads each first cluster and then every later one, and the result
// is loaded once the scan ends, or after the last item when n is below two
// throughput: one item per cycle while loading; input held off until the result is loaded
// reset: registers take their defaults, cluster count is zero, memory contents are not cleared
module cluster_pair_back_to_back_tagger #(
	parameter int MAX_CLUSTERS = cpbbt_pkg::MAX_CLUSTERS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [cpbbt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cpbbt_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// tower_id, energy_centi, energy_scale, phi_deg, theta_deg, theta_ring
	input  logic [47:0]                     s_tdata,
	// empty_marker
	input  logic                            s_tuser,
	// last_cluster
	input  logic                            s_tlast,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// veto_hit, veto_track_class, veto_tower_a, veto_tower_b, select_hit,
	// select_ring_class, select_tower_a, select_tower_b, low_pair_hit
	output logic [47:0]                     m_tdata
);

	localparam int IW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
	localparam int CW = $clog2(MAX_CLUSTERS + 1);

	localparam logic [1:0] ST_LOAD  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_OUT   = 2'd3;

	logic [1:0] state_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] cnt_nx;
	logic [CW-1:0] gi_q;
	logic [CW-1:0] gj_q;
	logic gph_q;

	logic [15:0] veto_lim_q;
	logic [15:0] sel_lim_q;
	logic [7:0]  ceil_q;
	logic [26:0] veto_win_q;
	logic [35:0] sel_win_q;
	logic [35:0] pair_win_q;
	logic [9:0]  ring_rng_q;

	cpbbt_pkg::cluster_t store_q [MAX_CLUSTERS];
	cpbbt_pkg::cluster_t rd_s1;
	logic rv_s1;
	logic rkind_s1;
	cpbbt_pkg::cluster_t a_q;

	logic veto_q;
	logic sel_q;
	logic low_q;
	logic [9:0] vta_q;
	logic [9:0] vtb_q;
	logic [9:0] sta_q;
	logic [9:0] stb_q;
	logic [4:0] vra_q;
	logic [4:0] vrb_q;
	logic [4:0] sra_q;
	logic [4:0] srb_q;

	logic m_tvalid_q;
	cpbbt_pkg::result_t m_tdata_q;

	logic in_acc;
	logic do_store;
	logic [IW-1:0] raddr;
	logic gen_last;
	logic out_load;

	logic [8:0] dabs;
	logic signed [10:0] dphi;
	logic [8:0] tsum;
	logic [11:0] ceil10;
	logic veto_pair;
	logic sel_pair;
	logic low_pair;

	logic [1:0] vclass;
	logic [2:0] sclass;
	logic [4:0] min_ring;
	cpbbt_pkg::result_t res;

	assign s_tready = (state_q == ST_LOAD);
	assign in_acc   = s_tvalid && s_tready;
	assign do_store = in_acc && !s_tuser && (cnt_q < CW'(MAX_CLUSTERS));
	assign cnt_nx   = do_store ? cnt_q + 1'b1 : cnt_q;

	assign raddr    = gph_q ? gj_q[IW-1:0] : gi_q[IW-1:0];
	assign gen_last = gph_q && (gj_q == cnt_q - 1'b1) && (gi_q == cnt_q - CW'(2));
	assign out_load = (state_q == ST_OUT) && (!m_tvalid_q || m_tready);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// pair tests on the held first cluster and the one just read
	always_comb begin
		dabs = (a_q.phi_deg >= rd_s1.phi_deg) ? a_q.phi_deg - rd_s1.phi_deg
			: rd_s1.phi_deg - a_q.phi_deg;
		dphi = (dabs > cpbbt_pkg::PHI_FOLD) ? $signed(cpbbt_pkg::PHI_FULL - {2'b00, dabs})
			: $signed({2'b00, dabs});
		tsum = {1'b0, a_q.theta_deg} + {1'b0, rd_s1.theta_deg};
		ceil10 = {4'd0, ceil_q} * {8'd0, cpbbt_pkg::CEILING_SCALE};
		veto_pair = cpbbt_pkg::phi_above(dphi, veto_win_q[8:0]) &&
			cpbbt_pkg::sum_window(tsum, veto_win_q[17:9], veto_win_q[26:18]) &&
			cpbbt_pkg::energy_pass(a_q, rd_s1, veto_lim_q);
		sel_pair = cpbbt_pkg::phi_above(dphi, sel_win_q[8:0]) &&
			cpbbt_pkg::phi_below(dphi, sel_win_q[17:9]) &&
			cpbbt_pkg::sum_window(tsum, sel_win_q[26:18], sel_win_q[35:27]) &&
			cpbbt_pkg::energy_pass(a_q, rd_s1, sel_lim_q);
		low_pair = cpbbt_pkg::phi_above(dphi, pair_win_q[8:0]) &&
			cpbbt_pkg::phi_below(dphi, pair_win_q[17:9]) &&
			cpbbt_pkg::sum_window(tsum, pair_win_q[26:18], pair_win_q[35:27]) &&
			(a_q.energy_centi < ceil10) && (rd_s1.energy_centi < ceil10);
	end

	// classes of the reported pairs
	always_comb begin
		vclass = cpbbt_pkg::VCLS_NONE;
		if (veto_q) begin
			if (vra_q >= ring_rng_q[4:0] && vra_q <= ring_rng_q[9:5] &&
				vrb_q >= ring_rng_q[4:0] && vrb_q <= ring_rng_q[9:5]) begin
				vclass = cpbbt_pkg::VCLS_INSIDE;
			end else begin
				vclass = cpbbt_pkg::VCLS_OUTSIDE;
			end
		end
		min_ring = (sra_q < srb_q) ? sra_q : srb_q;
		sclass = cpbbt_pkg::SCLS_NONE;
		if (sel_q) begin
			if (min_ring == 5'd0 || min_ring >= cpbbt_pkg::RING_LIMIT) begin
				sclass = cpbbt_pkg::SCLS_OUTSIDE;
			end else if (min_ring <= 5'd3) begin
				sclass = min_ring[2:0] + 3'd1;
			end else begin
				sclass = cpbbt_pkg::SCLS_OTHER;
			end
		end
		res.veto_hit          = veto_q;
		res.veto_track_class  = vclass;
		res.veto_tower_a      = veto_q ? vta_q : 10'd0;
		res.veto_tower_b      = veto_q ? vtb_q : 10'd0;
		res.select_hit        = sel_q;
		res.select_ring_class = sclass;
		res.select_tower_a    = sel_q ? sta_q : 10'd0;
		res.select_tower_b    = sel_q ? stb_q : 10'd0;
		res.low_pair_hit      = low_q;
	end

	// cluster memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (do_store) begin
			store_q[cnt_q[IW-1:0]] <= cpbbt_pkg::cluster_t'(s_tdata);
		end
		rd_s1 <= store_q[raddr];
	end

	// first cluster of the pair and result payload
	always_ff @(posedge clk) begin
		if (rv_s1 && !rkind_s1) begin
			a_q <= rd_s1;
		end
		if (rv_s1 && rkind_s1) begin
			if (veto_pair) begin
				vta_q <= a_q.tower_id;
				vtb_q <= rd_s1.tower_id;
				vra_q <= a_q.theta_ring;
				vrb_q <= rd_s1.theta_ring;
			end
			if (sel_pair) begin
				sta_q <= a_q.tower_id;
				stb_q <= rd_s1.tower_id;
				sra_q <= a_q.theta_ring;
				srb_q <= rd_s1.theta_ring;
			end
		end
		if (out_load) begin
			m_tdata_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			veto_lim_q <= cpbbt_pkg::VETO_LIMITS_RST;
			sel_lim_q  <= cpbbt_pkg::SELECT_LIMITS_RST;
			ceil_q     <= cpbbt_pkg::PAIR_CEILING_RST;
			veto_win_q <= cpbbt_pkg::VETO_WINDOW_RST;
			sel_win_q  <= cpbbt_pkg::SELECT_WINDOW_RST;
			pair_win_q <= cpbbt_pkg::PAIR_WINDOW_RST;
			ring_rng_q <= cpbbt_pkg::RING_RANGE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				cpbbt_pkg::REG_VETO_LIMITS:   veto_lim_q <= cfg_data[15:0];
				cpbbt_pkg::REG_SELECT_LIMITS: sel_lim_q  <= cfg_data[15:0];
				cpbbt_pkg::REG_PAIR_CEILING:  ceil_q     <= cfg_data[7:0];
				cpbbt_pkg::REG_VETO_WINDOW:   veto_win_q <= cfg_data[26:0];
				cpbbt_pkg::REG_SELECT_WINDOW: sel_win_q  <= cfg_data[35:0];
				cpbbt_pkg::REG_PAIR_WINDOW:   pair_win_q <= cfg_data[35:0];
				cpbbt_pkg::REG_RING_RANGE:    ring_rng_q <= cfg_data[9:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			cnt_q      <= '0;
			gi_q       <= '0;
			gj_q       <= '0;
			gph_q      <= 1'b0;
			rv_s1      <= 1'b0;
			rkind_s1   <= 1'b0;
			veto_q     <= 1'b0;
			sel_q      <= 1'b0;
			low_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			rv_s1    <= (state_q == ST_SCAN);
			rkind_s1 <= gph_q;
			if (rv_s1 && rkind_s1) begin
				if (veto_pair) veto_q <= 1'b1;
				if (sel_pair)  sel_q  <= 1'b1;
				if (low_pair)  low_q  <= 1'b1;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_LOAD: begin
					cnt_q <= cnt_nx;
					if (in_acc && s_tlast) begin
						gi_q   <= '0;
						gj_q   <= '0;
						gph_q  <= 1'b0;
						veto_q <= 1'b0;
						sel_q  <= 1'b0;
						low_q  <= 1'b0;
						state_q <= (cnt_nx < CW'(2)) ? ST_DRAIN : ST_SCAN;
					end
				end
				ST_SCAN: begin
					// read the first cluster, then every later one
					if (!gph_q) begin
						gph_q <= 1'b1;
						gj_q  <= gi_q + 1'b1;
					end else if (gen_last) begin
						state_q <= ST_DRAIN;
					end else if (gj_q == cnt_q - 1'b1) begin
						gi_q  <= gi_q + 1'b1;
						gph_q <= 1'b0;
					end else begin
						gj_q <= gj_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (!rv_s1) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						cnt_q      <= '0;
						state_q    <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_CLUSTERS))
		else $error("cluster count above store depth");

	a_scan_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> ({1'b0, raddr} < {1'b0, cnt_q}))
		else $error("scan reads beyond stored clusters");

	a_veto_class: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[0] == (m_tdata[2:1] != cpbbt_pkg::VCLS_NONE)))
		else $error("veto class disagrees with veto flag");

	a_sel_class: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[23] == (m_tdata[26:24] != cpbbt_pkg::SCLS_NONE)))
		else $error("selection class disagrees with selection flag");

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps
// self-checking testbench for the back-to-back cluster pair tagger
module tb;
	import cpbbt_pkg::*;

	localparam int STORE_DEPTH    = MAX_CLUSTERS_DEF;
	localparam int NUM_REGS       = 7;
	localparam int CYCLE_LIMIT    = 1000000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int TAIL_CYCLES    = 200;
	localparam int RANDOM_ITEMS   = 1450;
	localparam int STREAM_ITEMS   = 200;
	localparam int FINE_RING_LAST = 3;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

	typedef enum int {SET_DEFAULT, SET_ZERO, SET_ONES, SET_NOISE, SET_TYPICAL, SET_OPEN}
		setting_kind_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	// tower_id, energy_centi, energy_scale, phi_deg, theta_deg, theta_ring
	logic [47:0]           s_tdata;
	// empty_marker
	logic                  s_tuser;
	// last_cluster
	logic                  s_tlast;
	logic                  m_tvalid;
	logic                  m_tready;
	// veto_hit, veto_track_class, veto_tower_a, veto_tower_b, select_hit,
	// select_ring_class, select_tower_a, select_tower_b, low_pair_hit
	logic [47:0]           m_tdata;

	// register copies and cluster store of the predictor
	logic [15:0] veto_limits;
	logic [15:0] select_limits;
	logic [7:0]  pair_ceiling;
	logic [26:0] veto_window;
	logic [35:0] select_window;
	logic [35:0] pair_window;
	logic [9:0]  ring_range;
	cluster_t    held[STORE_DEPTH];
	int          held_count;

	result_t     expected_tags[$];
	logic [35:0] next_cfg[NUM_REGS];

	int fail_count  = 0;
	int items_sent  = 0;
	int cycle_count = 0;
	int hold_left   = 0;
	int stall_left  = 0;
	bit tx_idle_on  = 1'b1;
	bit rx_idle_on  = 1'b1;

	cluster_pair_back_to_back_tagger uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// ---------------------------------------------------------------- predictor

	function automatic int reg_width(int idx);
		case (idx)
			REG_VETO_LIMITS, REG_SELECT_LIMITS: return 16;
			REG_PAIR_CEILING:                   return 8;
			REG_VETO_WINDOW:                    return 27;
			REG_RING_RANGE:                     return 10;
			default:                            return 36;
		endcase
	endfunction

	function automatic void store_setting(int idx, logic [35:0] d);
		case (idx)
			REG_VETO_LIMITS:   veto_limits   = d[15:0];
			REG_SELECT_LIMITS: select_limits = d[15:0];
			REG_PAIR_CEILING:  pair_ceiling  = d[7:0];
			REG_VETO_WINDOW:   veto_window   = d[26:0];
			REG_SELECT_WINDOW: select_window = d;
			REG_PAIR_WINDOW:   pair_window   = d;
			REG_RING_RANGE:    ring_range    = d[9:0];
			default: ;
		endcase
	endfunction

	function automatic int nine(logic [35:0] v, int k);
		return int'((v >> (9 * k)) & 36'h1FF);
	endfunction

	function automatic bit energies_clear(cluster_t a, cluster_t b, logic [15:0] lim);
		int lo;
		int hi;
		bit both;
		bit one;
		lo = int'(lim[7:0]);
		hi = int'(lim[15:8]);
		both = int'(a.energy_centi) > lo * int'(a.energy_scale) &&
			int'(b.energy_centi) > lo * int'(b.energy_scale);
		one = int'(a.energy_centi) > hi * int'(a.energy_scale) ||
			int'(b.energy_centi) > hi * int'(b.energy_scale);
		return both && one;
	endfunction

	// scan all pairs i < j; the last qualifying pair of each tag is reported
	function automatic void tag_event();
		result_t  r;
		cluster_t a;
		cluster_t b;
		int dphi, tsum, ceil10, m;
		int vra, vrb, sra, srb;
		r = '0;
		vra = 0; vrb = 0; sra = 0; srb = 0;
		ceil10 = int'(pair_ceiling) * int'(CEILING_SCALE);
		for (int i = 0; i < held_count; i++) begin
			for (int j = i + 1; j < held_count; j++) begin
				a = held[i];
				b = held[j];
				dphi = int'(a.phi_deg) - int'(b.phi_deg);
				if (dphi < 0) dphi = -dphi;
				// folding can go negative since phi reaches 511
				if (dphi > int'(PHI_FOLD)) dphi = int'(PHI_FULL) - dphi;
				tsum = int'(a.theta_deg) + int'(b.theta_deg);
				if (dphi > nine(veto_window, 0) && tsum > nine(veto_window, 1) &&
						tsum < nine(veto_window, 2) &&
						energies_clear(a, b, veto_limits)) begin
					r.veto_hit = 1'b1;
					r.veto_tower_a = a.tower_id;
					r.veto_tower_b = b.tower_id;
					vra = int'(a.theta_ring);
					vrb = int'(b.theta_ring);
				end
				if (dphi > nine(select_window, 0) && dphi < nine(select_window, 1) &&
						tsum > nine(select_window, 2) && tsum < nine(select_window, 3) &&
						energies_clear(a, b, select_limits)) begin
					r.select_hit = 1'b1;
					r.select_tower_a = a.tower_id;
					r.select_tower_b = b.tower_id;
					sra = int'(a.theta_ring);
					srb = int'(b.theta_ring);
				end
				if (dphi > nine(pair_window, 0) && dphi < nine(pair_window, 1) &&
						tsum > nine(pair_window, 2) && tsum < nine(pair_window, 3) &&
						int'(a.energy_centi) < ceil10 && int'(b.energy_centi) < ceil10)
					r.low_pair_hit = 1'b1;
			end
		end
		if (!r.veto_hit)
			r.veto_track_class = VCLS_NONE;
		else if (vra >= int'(ring_range[4:0]) && vra <= int'(ring_range[9:5]) &&
				vrb >= int'(ring_range[4:0]) && vrb <= int'(ring_range[9:5]))
			r.veto_track_class = VCLS_INSIDE;
		else
			r.veto_track_class = VCLS_OUTSIDE;
		m = (sra < srb) ? sra : srb;
		if (!r.select_hit)
			r.select_ring_class = SCLS_NONE;
		else if (m == 0 || m >= int'(RING_LIMIT))
			r.select_ring_class = SCLS_OUTSIDE;
		else if (m <= FINE_RING_LAST)
			r.select_ring_class = 3'(m + 1);
		else
			r.select_ring_class = SCLS_OTHER;
		expected_tags = {expected_tags, r};
	endfunction

	function automatic void absorb_item(cluster_t c, bit last, bit empty);
		if (!empty && held_count < STORE_DEPTH) begin
			held[held_count] = c;
			held_count++;
		end
		if (last) begin
			tag_event();
			held_count = 0;
		end
	endfunction

	// ---------------------------------------------------------------- result side

	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(0, 18);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (expected_tags.size() == 0) begin
				$error("result transaction with no event pending: %h", m_tdata);
				fail_count++;
			end else begin
				want = expected_tags.pop_front();
				check_field("veto_hit", int'(want.veto_hit), int'(got.veto_hit));
				check_field("veto_track_class", int'(want.veto_track_class),
					int'(got.veto_track_class));
				check_field("veto_tower_a", int'(want.veto_tower_a),
					int'(got.veto_tower_a));
				check_field("veto_tower_b", int'(want.veto_tower_b),
					int'(got.veto_tower_b));
				check_field("select_hit", int'(want.select_hit), int'(got.select_hit));
				check_field("select_ring_class", int'(want.select_ring_class),
					int'(got.select_ring_class));
				check_field("select_tower_a", int'(want.select_tower_a),
					int'(got.select_tower_a));
				check_field("select_tower_b", int'(want.select_tower_b),
					int'(got.select_tower_b));
				check_field("low_pair_hit", int'(want.low_pair_hit),
					int'(got.low_pair_hit));
			end
		end
	end

	// ---------------------------------------------------------------- cluster side

	task automatic send_item(input cluster_t c, input bit last, input bit empty);
		int gap;
		gap = (tx_idle_on && $urandom_range(0, 7) == 0) ? $urandom_range(1, 19) : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tuser  <= empty;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		absorb_item(c, last, empty);
		if (last || !empty) items_sent++;
	endtask

	// drop valid and wait for every pending result, then let the block settle
	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_tags.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic cluster_t cl(int tower, int energy, int scale, int phi, int theta,
			int ring);
		cluster_t c;
		c.tower_id     = 10'(tower);
		c.energy_centi = 12'(energy);
		c.energy_scale = 4'(scale);
		c.phi_deg      = 9'(phi);
		c.theta_deg    = 8'(theta);
		c.theta_ring   = 5'(ring);
		return c;
	endfunction

	function automatic int some_energy();
		case ($urandom_range(0, 2))
			0:       return $urandom_range(0, 4095);
			1:       return $urandom_range(0, 800);
			default: return $urandom_range(0, 300);
		endcase
	endfunction

	// a quarter of clusters are raw noise over every bit, the rest plausible
	function automatic cluster_t any_cluster();
		cluster_t c;
		c = 48'({$urandom, $urandom});
		if ($urandom_range(0, 3) != 0) begin
			c.phi_deg      = 9'($urandom_range(0, 359));
			c.theta_deg    = 8'($urandom_range(20, 160));
			c.theta_ring   = 5'($urandom_range(0, 22));
			c.energy_centi = 12'(some_energy());
			c.energy_scale = 4'($urandom_range(0, 15));
		end
		return c;
	endfunction

	// roughly opposite in phi, theta sum near the usual windows
	function automatic cluster_t back_partner(cluster_t a);
		cluster_t b;
		int phi;
		int th;
		b = any_cluster();
		phi = int'(a.phi_deg) + int'(PHI_FOLD) + int'($urandom_range(0, 50)) - 25;
		th = int'($urandom_range(150, 215)) - int'(a.theta_deg);
		if (th < 0) th = 0;
		if (th > 255) th = 255;
		b.phi_deg = 9'(phi % int'(PHI_FULL));
		b.theta_deg = 8'(th);
		return b;
	endfunction

	task automatic send_event(input int n, input bit trailer);
		cluster_t c;
		cluster_t prev;
		bit end_alone;
		end_alone = trailer || n == 0;
		prev = any_cluster();
		for (int k = 0; k < n; k++) begin
			c = (k > 0 && $urandom_range(0, 1)) ? back_partner(prev) : any_cluster();
			if ($urandom_range(0, 19) == 0) send_item(any_cluster(), 1'b0, 1'b1);
			send_item(c, !end_alone && k == n - 1, 1'b0);
			prev = c;
		end
		if (end_alone) send_item(any_cluster(), 1'b1, 1'b1);
	endtask

	function automatic int pick_size();
		case ($urandom_range(0, 19))
			0:       return 0;
			1:       return 1;
			2:       return $urandom_range(STORE_DEPTH, STORE_DEPTH + 3);
			default: return $urandom_range(2, 7);
		endcase
	endfunction

	// ---------------------------------------------------------------- settings

	function automatic logic [35:0] win4(int f0, int f1, int f2, int f3);
		return {9'(f3), 9'(f2), 9'(f1), 9'(f0)};
	endfunction

	function automatic logic [35:0] lims(int lo, int hi);
		return 36'({8'(hi), 8'(lo)});
	endfunction

	function automatic void fill_settings(setting_kind_t kind);
		case (kind)
			SET_DEFAULT: begin
				next_cfg[REG_VETO_LIMITS]   = 36'(VETO_LIMITS_RST);
				next_cfg[REG_SELECT_LIMITS] = 36'(SELECT_LIMITS_RST);
				next_cfg[REG_PAIR_CEILING]  = 36'(PAIR_CEILING_RST);
				next_cfg[REG_VETO_WINDOW]   = 36'(VETO_WINDOW_RST);
				next_cfg[REG_SELECT_WINDOW] = SELECT_WINDOW_RST;
				next_cfg[REG_PAIR_WINDOW]   = PAIR_WINDOW_RST;
				next_cfg[REG_RING_RANGE]    = 36'(RING_RANGE_RST);
			end
			SET_ZERO, SET_ONES, SET_NOISE: begin
				for (int k = 0; k < NUM_REGS; k++)
					next_cfg[k] = (kind == SET_ZERO) ? '0 :
						(kind == SET_ONES) ? '1 : 36'({$urandom, $urandom});
			end
			SET_OPEN: begin
				next_cfg[REG_VETO_LIMITS]   = lims(0, 0);
				next_cfg[REG_SELECT_LIMITS] = lims(0, 0);
				next_cfg[REG_PAIR_CEILING]  = 36'd255;
				next_cfg[REG_VETO_WINDOW]   = win4(0, 0, 511, 0);
				next_cfg[REG_SELECT_WINDOW] = win4(0, 511, 0, 511);
				next_cfg[REG_PAIR_WINDOW]   = win4(0, 511, 0, 511);
				next_cfg[REG_RING_RANGE]    = 36'({5'd31, 5'd0});
			end
			default: begin
				next_cfg[REG_VETO_LIMITS] = lims($urandom_range(0, 50), $urandom_range(0, 80));
				next_cfg[REG_SELECT_LIMITS] =
					lims($urandom_range(0, 50), $urandom_range(0, 80));
				next_cfg[REG_PAIR_CEILING] = 36'($urandom_range(5, 80));
				next_cfg[REG_VETO_WINDOW] = win4($urandom_range(120, 180),
					$urandom_range(140, 175), $urandom_range(176, 230), 0);
				next_cfg[REG_SELECT_WINDOW] = win4($urandom_range(100, 179),
					$urandom_range(181, 260), $urandom_range(130, 175),
					$urandom_range(176, 240));
				next_cfg[REG_PAIR_WINDOW] = win4($urandom_range(100, 179),
					$urandom_range(181, 260), $urandom_range(130, 175),
					$urandom_range(176, 240));
				next_cfg[REG_RING_RANGE] =
					36'({5'($urandom_range(5, 25)), 5'($urandom_range(0, 10))});
			end
		endcase
	endfunction

	// every register is written, with noise above its width, then the unused index
	task automatic apply_settings(input setting_kind_t kind);
		logic [35:0] junk;
		fill_settings(kind);
		wait_idle();
		for (int k = 0; k < NUM_REGS; k++) begin
			junk = 36'({$urandom, $urandom});
			next_cfg[k] = next_cfg[k] | (junk & ~((36'd1 << reg_width(k)) - 36'd1));
			cfg_we    <= 1'b1;
			cfg_index <= k[CFG_IDX_W-1:0];
			cfg_data  <= next_cfg[k];
			@(posedge clk);
			store_setting(k, next_cfg[k]);
			@(negedge clk);
		end
		cfg_index <= REG_SPARE;
		cfg_data  <= 36'({$urandom, $urandom});
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic setting_kind_t pick_kind();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5) return SET_TYPICAL;
		if (r < 7) return SET_OPEN;
		if (r < 9) return SET_NOISE;
		return SET_DEFAULT;
	endfunction

	// ---------------------------------------------------------------- tests

	task automatic test_reset_values();
		int rings[6];
		rings = '{0, 1, 2, 3, 4, 18};
		// opposite pair passing veto and selection under reset values
		send_item(cl(10, 4095, 1, 0, 80, 5), 1'b0, 1'b0);
		send_item(cl(20, 4095, 1, 180, 95, 6), 1'b1, 1'b0);
		// zero energies: only the low-energy pair can fire
		send_item(cl(30, 0, 0, 90, 100, 0), 1'b0, 1'b0);
		send_item(cl(40, 0, 0, 270, 75, 0), 1'b1, 1'b0);
		// field extremes, folded phi difference goes negative
		send_item(cl(1023, 4095, 15, 511, 255, 31), 1'b0, 1'b0);
		send_item(cl(0, 0, 0, 0, 0, 0), 1'b1, 1'b0);
		// lone cluster, then an empty end marker on its own
		send_item(cl(5, 2000, 2, 45, 90, 4), 1'b1, 1'b0);
		send_item(cl(1023, 4095, 15, 511, 255, 31), 1'b1, 1'b1);
		// empty item inside an event, closed by an empty end marker
		send_item(cl(7, 3000, 1, 100, 90, 9), 1'b0, 1'b0);
		send_item(cl(1023, 4095, 15, 511, 255, 31), 1'b0, 1'b1);
		send_item(cl(8, 3000, 1, 280, 85, 2), 1'b0, 1'b0);
		send_item(cl(0, 0, 0, 0, 0, 0), 1'b1, 1'b1);
		// smaller-ring bands of the selection class, veto ring range in and out
		foreach (rings[k]) begin
			send_item(cl(100 + k, 4095, 1, 10, 80, rings[k]), 1'b0, 1'b0);
			send_item(cl(200 + k, 4095, 1, 190, 95, rings[k] == 4 ? 10 : 20), 1'b1, 1'b0);
		end
	endtask

	task automatic test_store_overflow();
		wait_idle();
		send_event(STORE_DEPTH + 3, 1'b0);
		send_event(STORE_DEPTH, 1'b1);
		// the end item itself is dropped once the store is full
		send_event(STORE_DEPTH + 1, 1'b0);
	endtask

	task automatic test_register_sweep();
		setting_kind_t kinds[6];
		kinds = '{SET_ZERO, SET_ONES, SET_OPEN, SET_TYPICAL, SET_NOISE, SET_DEFAULT};
		foreach (kinds[k]) begin
			apply_settings(kinds[k]);
			repeat (20) send_event(pick_size(), $urandom_range(0, 3) == 0);
		end
	endtask

	task automatic test_output_backpressure();
		apply_settings(SET_OPEN);
		hold_left = 500;
		repeat (4) send_event(STORE_DEPTH, 1'b0);
		// sender pauses until the last result is out
		wait_idle();
	endtask

	task automatic test_random_traffic();
		int events;
		events = 0;
		while (items_sent < RANDOM_ITEMS) begin
			if (events % 40 == 0) apply_settings(pick_kind());
			send_event(pick_size(), $urandom_range(0, 3) == 0);
			events++;
		end
	endtask

	task automatic test_full_rate();
		int target;
		apply_settings(SET_TYPICAL);
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		target = items_sent + STREAM_ITEMS;
		while (items_sent < target) send_event(pick_size(), $urandom_range(0, 3) == 0);
	endtask

	initial begin
		clk       = 1'b0;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = 1'b0;
		s_tlast   = 1'b0;
		m_tready  = 1'b0;
		held_count = 0;
		fill_settings(SET_DEFAULT);
		for (int k = 0; k < NUM_REGS; k++) store_setting(k, next_cfg[k]);
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_values();
		test_store_overflow();
		test_register_sweep();
		test_output_backpressure();
		test_random_traffic();
		test_full_rate();

		wait_idle();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

/* sim.f */
rtl/core/cpbbt_pkg.sv
rtl/core/cluster_pair_back_to_back_tagger.sv
dv/tb.sv
